// ===== rtl/core/paeptw_pkg.sv =====
// ----------------------------------------------------------------------------
// paeptw_pkg
// Types and constants shared by the PAE page table walker modules.
// ----------------------------------------------------------------------------
package paeptw_pkg;

  localparam logic [1:0] PHASE_IDLE  = 2'd0;
  localparam logic [1:0] PHASE_PDPTE = 2'd1;
  localparam logic [1:0] PHASE_PDE   = 2'd2;
  localparam logic [1:0] PHASE_PTE   = 2'd3;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_FAULT  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [1:0] LEVEL_PDPTE = 2'd0;
  localparam logic [1:0] LEVEL_PDE   = 2'd1;
  localparam logic [1:0] LEVEL_PTE   = 2'd2;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_DATA      = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] vaddr;
    logic [31:0] table_base;
    logic [63:0] read_data;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] read_address;
    logic [35:0] phys_address;
    logic        large_page;
    logic [1:0]  fault_level;
  } result_t;

endpackage

// ===== rtl/core/paeptw_step.sv =====
// ----------------------------------------------------------------------------
// paeptw_step
// One walk step: decodes a request against the walk phase and builds the
// result and the next walk state.
// ----------------------------------------------------------------------------
module paeptw_step (
  input  paeptw_pkg::item_t   item,
  input  logic [1:0]          phase,
  input  logic [31:0]         held_va,
  input  logic                win_en,
  output paeptw_pkg::result_t res,
  output logic [1:0]          phase_nxt,
  output logic [31:0]         held_va_nxt
);

  logic        present;
  logic [63:0] e;

  assign e       = item.read_data;
  assign present = e[0] | (win_en & e[11] & ~e[10]);

  always_comb begin
    res         = '0;
    phase_nxt   = phase;
    held_va_nxt = held_va;
    if (item.req_type == paeptw_pkg::REQ_TRANSLATE) begin
      if (phase != paeptw_pkg::PHASE_IDLE) begin
        res.result_kind = paeptw_pkg::KIND_REJECT;
      end else begin
        held_va_nxt      = item.vaddr;
        phase_nxt        = paeptw_pkg::PHASE_PDPTE;
        res.result_kind  = paeptw_pkg::KIND_READ;
        res.read_address = {item.table_base[31:5], item.vaddr[31:30], 3'b000};
      end
    end else begin
      unique case (phase)
        paeptw_pkg::PHASE_PDPTE: begin
          if (!present) begin
            phase_nxt       = paeptw_pkg::PHASE_IDLE;
            res.result_kind = paeptw_pkg::KIND_FAULT;
            res.fault_level = paeptw_pkg::LEVEL_PDPTE;
          end else begin
            phase_nxt        = paeptw_pkg::PHASE_PDE;
            res.result_kind  = paeptw_pkg::KIND_READ;
            res.read_address = {e[31:12], held_va[29:21], 3'b000};
          end
        end
        paeptw_pkg::PHASE_PDE: begin
          if (!present) begin
            phase_nxt       = paeptw_pkg::PHASE_IDLE;
            res.result_kind = paeptw_pkg::KIND_FAULT;
            res.fault_level = paeptw_pkg::LEVEL_PDE;
          end else if (e[7]) begin
            phase_nxt        = paeptw_pkg::PHASE_IDLE;
            res.result_kind  = paeptw_pkg::KIND_DONE;
            res.phys_address = {e[35:21], held_va[20:0]};
            res.large_page   = 1'b1;
          end else begin
            phase_nxt        = paeptw_pkg::PHASE_PTE;
            res.result_kind  = paeptw_pkg::KIND_READ;
            res.read_address = {e[31:12], held_va[20:12], 3'b000};
          end
        end
        paeptw_pkg::PHASE_PTE: begin
          phase_nxt = paeptw_pkg::PHASE_IDLE;
          if (!present) begin
            res.result_kind = paeptw_pkg::KIND_FAULT;
            res.fault_level = paeptw_pkg::LEVEL_PTE;
          end else begin
            res.result_kind  = paeptw_pkg::KIND_DONE;
            res.phys_address = {e[35:12], held_va[11:0]};
          end
        end
        default: begin
          res.result_kind = paeptw_pkg::KIND_REJECT;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pae_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// pae_page_table_walker
// Three-level PAE page table walker advanced one request at a time.
//
// channel  direction  handshake          payload
// in       input      in_vld / in_stall  req_type, vaddr, table_base,
//                                        read_data
// out      output     out_vld/out_stall  result_kind, read_address,
//                                        phys_address, large_page, fault_level
// cfg      input      cfg_wr_en          cfg_wr_data (windows transition enable)
//
// A request passes the input register, one step of decode and address
// logic, and the result register. One request per cycle sustained unless out_stall holds the result.
// Synchronous active-low reset returns the walk to idle and clears the option.
// A stalled result holds the result register; the input register still takes
// a request if the result register frees in the same cycle.
// ----------------------------------------------------------------------------
module pae_page_table_walker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_vld,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_vaddr,
  input  logic [31:0] in_table_base,
  input  logic [63:0] in_read_data,
  output logic        out_vld,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_read_address,
  output logic [35:0] out_phys_address,
  output logic        out_large_page,
  output logic [1:0]  out_fault_level
);

  logic                in_vld_r, in_vld_nxt;
  paeptw_pkg::item_t   item_r;
  logic                out_vld_r, out_vld_nxt;
  paeptw_pkg::result_t res_r;
  paeptw_pkg::result_t res_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [31:0]         held_va_r, held_va_nxt;
  logic                win_en_r;
  logic                accept;
  logic                advance;

  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;
  assign accept   = in_vld & ~in_stall;

  assign in_vld_nxt  = accept | (in_vld_r & ~advance);
  assign out_vld_nxt = advance | (out_vld_r & out_stall);

  paeptw_step u_step (
    .item        (item_r),
    .phase       (phase_r),
    .held_va     (held_va_r),
    .win_en      (win_en_r),
    .res         (res_nxt),
    .phase_nxt   (phase_nxt),
    .held_va_nxt (held_va_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= paeptw_pkg::PHASE_IDLE;
      held_va_r <= '0;
      win_en_r  <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        win_en_r <= cfg_wr_data;
      end
      if (advance) begin
        phase_r   <= phase_nxt;
        held_va_r <= held_va_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.req_type   <= in_req_type;
      item_r.vaddr      <= in_vaddr;
      item_r.table_base <= in_table_base;
      item_r.read_data  <= in_read_data;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_vld          = out_vld_r;
  assign out_result_kind  = res_r.result_kind;
  assign out_read_address = res_r.read_address;
  assign out_phys_address = res_r.phys_address;
  assign out_large_page   = res_r.large_page;
  assign out_fault_level  = res_r.fault_level;

  // rejected requests leave the walk untouched
  a_reject_keeps_walk: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.result_kind == paeptw_pkg::KIND_REJECT
    |=> $stable(phase_r) && $stable(held_va_r))
    else $error("rejected request changed walk state");

  // a finished or faulted walk returns to idle
  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res_nxt.result_kind == paeptw_pkg::KIND_DONE ||
                res_nxt.result_kind == paeptw_pkg::KIND_FAULT)
    |=> phase_r == paeptw_pkg::PHASE_IDLE)
    else $error("walk not idle after completion");

  // a read request always leaves the walk waiting for data
  a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.result_kind == paeptw_pkg::KIND_READ
    |=> phase_r != paeptw_pkg::PHASE_IDLE)
    else $error("read issued but walk idle");

  // only done results carry a physical address or page size
  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_result_kind != paeptw_pkg::KIND_DONE
    |-> out_phys_address == '0 && !out_large_page)
    else $error("translation fields set on non-done result");

endmodule
